// File: hw/rtl/stlat_pkg.sv
// ----------------------------------------------------------------------------
// stlat_pkg
// Shared types and constants for the stage latency statistics unit.
// ----------------------------------------------------------------------------
package stlat_pkg;

  localparam int unsigned NumStagesDefault = 16;
  localparam int unsigned StageW           = 6;
  localparam logic [31:0] IntervalReset    = 32'd1000;

  typedef enum logic [1:0] {
    OP_DURATION = 2'd0,
    OP_EVENTS   = 2'd1,
    OP_PERIODIC = 2'd2,
    OP_FLUSH    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [StageW-1:0]  stage_index;
    logic [31:0]        amount;
    logic [47:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [StageW-1:0]  stage_id;
    logic [31:0]        sample_count;
    logic [63:0]        average_us;
    logic [31:0]        max_us;
    logic [63:0]        event_total;
    logic               last_in_report;
  } out_item_t;

  // One row of the statistics memory
  typedef struct packed {
    logic [31:0] count;
    logic [63:0] sum;
    logic [31:0] max;
    logic [63:0] events;
  } entry_t;

  // Memory control from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic              clr_all;
    logic [StageW-1:0] rd_addr;
    logic [StageW-1:0] wr_addr;
  } mem_ctl_t;

endpackage

// File: hw/rtl/stlat_stat_mem.sv
// ----------------------------------------------------------------------------
// stlat_stat_mem
// Per-stage statistics memory with a registered read port and a valid bit per
// row so that rows read as zero after reset or after a report.
// ----------------------------------------------------------------------------
module stlat_stat_mem #(
  parameter int unsigned NumStages = stlat_pkg::NumStagesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stlat_pkg::mem_ctl_t ctl_i,
  input  stlat_pkg::entry_t   wr_data_i,
  output stlat_pkg::entry_t   rd_data_o
);
  import stlat_pkg::*;

  localparam int unsigned AddrW = (NumStages > 1) ? $clog2(NumStages) : 1;

  entry_t               mem [NumStages];
  logic [NumStages-1:0] vld_q;
  entry_t               rd_q;
  logic                 rd_vld_q;

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  assign rd_addr = ctl_i.rd_addr[AddrW-1:0];
  assign wr_addr = ctl_i.wr_addr[AddrW-1:0];

  // Storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data_i;
    end
    rd_q <= mem[rd_addr];
  end

  // Row valid bits; a report clears them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (ctl_i.clr_all) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/stlat_div.sv
// ----------------------------------------------------------------------------
// stlat_div
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stlat_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [63:0] quot_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [32:0] rem_sh;
  logic [32:0] trial;
  logic        fits;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_q, quot_q[63]};
  assign trial  = rem_sh - {1'b0, div_q};
  assign fits   = (rem_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[62:0], fits};
      rem_q  <= fits ? trial[31:0] : rem_sh[31:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: hw/rtl/stage_latency_statistics_unit.sv
// ----------------------------------------------------------------------------
// stage_latency_statistics_unit
// Per-stage count, sum, maximum and event statistics kept in a memory, with
// periodic and flush reports that emit one entry per non-empty stage.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  stlat_pkg::in_item_t
//   out      output     out_valid_o/out_stall_i stlat_pkg::out_item_t
//   cfg      input      cfg_we_i              cfg_wdata_i (report interval)
//
// A record is accepted with its memory read, then modified and written back.
// A report check with nothing due leaves the unit ready for the next item.
// A report (flush, or a check that is due) sweeps the memory in S_SCAN, then
// walks the stages in S_FIND; each reported stage is read, divided by the
// 64-step bit-serial divider and held while the output is stalled.
// Reset clears all rows through their valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stage_latency_statistics_unit #(
  parameter int unsigned NumStages = stlat_pkg::NumStagesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  stlat_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output stlat_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i
);
  import stlat_pkg::*;

  localparam int unsigned AddrW = (NumStages > 1) ? $clog2(NumStages) : 1;
  localparam int unsigned CntW  = $clog2(NumStages + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_SCAN,
    S_FIND,
    S_READ,
    S_DIV,
    S_OUT
  } state_e;

  state_e               state_q;
  in_item_t             item_q;
  logic [31:0]          interval_q;
  logic [47:0]          last_time_q;
  logic                 known_q;
  logic [CntW-1:0]      ptr_q;
  logic [NumStages-1:0] mask_q;
  entry_t               ent_q;
  out_item_t            out_q;
  logic                 out_valid_q;
  logic                 div_start_q;

  mem_ctl_t  mem_ctl;
  entry_t    rd_data;
  entry_t    wr_data;
  logic      div_done;
  logic [63:0] quot;

  logic        accept;
  logic        in_range;
  logic [47:0] elapsed;
  logic        due;
  logic        ptr_end;
  logic        above_any;
  logic [CntW-1:0] prev_ptr;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_range = ({1'b0, in_item_i.stage_index} < (StageW + 1)'(NumStages));
  assign elapsed  = in_item_i.now_ms - last_time_q;
  assign due      = known_q && (in_item_i.now_ms >= last_time_q) &&
                    (elapsed >= {16'd0, interval_q});
  assign ptr_end  = (ptr_q == CntW'(NumStages));
  assign prev_ptr = ptr_q - CntW'(1);

  // Any non-empty stage above the current one
  always_comb begin
    above_any = 1'b0;
    for (int i = 0; i < NumStages; i++) begin
      if ((CntW + 1)'(i) > {1'b0, ptr_q}) begin
        above_any = above_any | mask_q[i];
      end
    end
  end

  // Read-modify-write of one record
  always_comb begin
    wr_data = rd_data;
    if (item_q.operation == OP_DURATION) begin
      if (rd_data.count != 32'hFFFF_FFFF) begin
        wr_data.count = rd_data.count + 32'd1;
      end
      wr_data.sum = rd_data.sum + {32'd0, item_q.amount};
      if (item_q.amount > rd_data.max) begin
        wr_data.max = item_q.amount;
      end
    end else begin
      wr_data.events = rd_data.events + {32'd0, item_q.amount};
    end
  end

  // Memory address and write control
  always_comb begin
    mem_ctl         = '0;
    mem_ctl.wr_addr = item_q.stage_index;
    case (state_q)
      S_IDLE:  mem_ctl.rd_addr = in_item_i.stage_index;
      S_REC:   mem_ctl.wr_en   = 1'b1;
      S_SCAN:  mem_ctl.rd_addr = StageW'(ptr_q[AddrW-1:0]);
      S_FIND: begin
        mem_ctl.rd_addr = StageW'(ptr_q[AddrW-1:0]);
        mem_ctl.clr_all = ptr_end;
      end
      default: mem_ctl.rd_addr = '0;
    endcase
  end

  stlat_stat_mem #(
    .NumStages (NumStages)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  stlat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (ent_q.sum),
    .divisor_i  (ent_q.count),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Sequencer: records, report check, scan and emission passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      interval_q  <= IntervalReset;
      last_time_q <= '0;
      known_q     <= 1'b0;
      ptr_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_item_i.operation)
              OP_DURATION, OP_EVENTS: begin
                if (in_range) begin
                  state_q <= S_REC;
                end
              end
              OP_PERIODIC: begin
                if (!known_q) begin
                  known_q     <= 1'b1;
                  last_time_q <= in_item_i.now_ms;
                end else if (due) begin
                  last_time_q <= in_item_i.now_ms;
                  ptr_q       <= '0;
                  mask_q      <= '0;
                  state_q     <= S_SCAN;
                end
              end
              default: begin
                ptr_q   <= '0;
                mask_q  <= '0;
                state_q <= S_SCAN;
              end
            endcase
          end
        end
        S_REC: state_q <= S_IDLE;
        S_SCAN: begin
          // data of the previous address arrives this cycle
          if (ptr_q != '0) begin
            mask_q[prev_ptr[AddrW-1:0]] <= (rd_data.count != '0) ||
                                           (rd_data.events != '0);
          end
          if (ptr_end) begin
            ptr_q   <= '0;
            state_q <= S_FIND;
          end else begin
            ptr_q <= ptr_q + CntW'(1);
          end
        end
        S_FIND: begin
          if (ptr_end) begin
            state_q <= S_IDLE;
          end else if (mask_q[ptr_q[AddrW-1:0]]) begin
            state_q <= S_READ;
          end else begin
            ptr_q <= ptr_q + CntW'(1);
          end
        end
        S_READ: begin
          div_start_q <= 1'b1;
          state_q     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            ptr_q       <= ptr_q + CntW'(1);
            state_q     <= S_FIND;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (state_q == S_READ) begin
      ent_q <= rd_data;
    end
    if (state_q == S_DIV && div_done) begin
      out_q.stage_id       <= StageW'(ptr_q[AddrW-1:0]);
      out_q.sample_count   <= ent_q.count;
      out_q.average_us     <= (ent_q.count == '0) ? 64'd0 : quot;
      out_q.max_us         <= ent_q.max;
      out_q.event_total    <= ent_q.events;
      out_q.last_in_report <= !above_any;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Output only shows while the input side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result presented while accepting input");

  // Every reported stage has something to report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.sample_count != '0 || out_item_o.event_total != '0))
    else $error("empty stage reported");

  // A write-back comes in the cycle after an accepted record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> $past(accept))
    else $error("write-back without a record");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result out of sequence");

endmodule

// File: tb/sv/stage_latency_statistics_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_latency_statistics_unit_checker
// Watches the input, output and interval-write ports of the unit, keeps its own
// copy of the per-stage statistics, predicts the report entries of every
// accepted transfer and compares them field by field with the block's output.
// ----------------------------------------------------------------------------
module stage_latency_statistics_unit_checker #(
  parameter int unsigned NumStages = stlat_pkg::NumStagesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  stlat_pkg::in_item_t  in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  stlat_pkg::out_item_t out_item_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import stlat_pkg::*;

  logic [31:0] interval_q;
  logic [31:0] cnt_q [NumStages];
  logic [63:0] sum_q [NumStages];
  logic [31:0] max_q [NumStages];
  logic [63:0] evt_q [NumStages];
  logic [47:0] last_time_q;
  logic        time_known_q;

  out_item_t expected_entries [$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_entries.size();

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  // Sweep every stage, queue an entry for each non-empty one, clear all
  task automatic predict_report();
    out_item_t e;
    int        last_idx;
    last_idx = -1;
    for (int s = 0; s < NumStages; s++) begin
      if (cnt_q[s] != 0 || evt_q[s] != 0) begin
        e.stage_id       = s[StageW-1:0];
        e.sample_count   = cnt_q[s];
        e.average_us     = (cnt_q[s] != 0) ? sum_q[s] / {32'd0, cnt_q[s]} : 64'd0;
        e.max_us         = max_q[s];
        e.event_total    = evt_q[s];
        e.last_in_report = 1'b0;
        expected_entries.push_back(e);
        last_idx = expected_entries.size() - 1;
      end
      cnt_q[s] = '0;
      sum_q[s] = '0;
      max_q[s] = '0;
      evt_q[s] = '0;
    end
    if (last_idx >= 0) expected_entries[last_idx].last_in_report = 1'b1;
  endtask

  task automatic apply_transfer(input in_item_t it);
    int unsigned st;
    st = it.stage_index;
    case (it.operation)
      OP_DURATION: begin
        if (st < NumStages) begin
          if (cnt_q[st] != 32'hFFFF_FFFF) cnt_q[st] = cnt_q[st] + 1;
          sum_q[st] = sum_q[st] + {32'd0, it.amount};
          if (it.amount > max_q[st]) max_q[st] = it.amount;
        end
      end
      OP_EVENTS: begin
        if (st < NumStages) evt_q[st] = evt_q[st] + {32'd0, it.amount};
      end
      OP_PERIODIC: begin
        if (!time_known_q) begin
          time_known_q = 1'b1;
          last_time_q  = it.now_ms;
        end else if (it.now_ms >= last_time_q &&
                     ({16'd0, it.now_ms - last_time_q} >= {32'd0, interval_q})) begin
          last_time_q = it.now_ms;
          predict_report();
        end
      end
      default: predict_report();
    endcase
  endtask

  // Model update and output compare at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= IntervalReset;
      last_time_q  <= '0;
      time_known_q <= 1'b0;
      for (int s = 0; s < NumStages; s++) begin
        cnt_q[s] <= '0;
        sum_q[s] <= '0;
        max_q[s] <= '0;
        evt_q[s] <= '0;
      end
      expected_entries.delete();
      fails <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected entry for stage %0d", out_item_i.stage_id));
        end else begin
          out_item_t x;
          x = expected_entries.pop_front();
          if (out_item_i.stage_id != x.stage_id)
            report_mismatch($sformatf("stage_id %0d, want %0d",
                                      out_item_i.stage_id, x.stage_id));
          if (out_item_i.sample_count != x.sample_count)
            report_mismatch($sformatf("stage %0d sample_count %0d, want %0d",
                            x.stage_id, out_item_i.sample_count, x.sample_count));
          if (out_item_i.average_us != x.average_us)
            report_mismatch($sformatf("stage %0d average_us %0d, want %0d",
                            x.stage_id, out_item_i.average_us, x.average_us));
          if (out_item_i.max_us != x.max_us)
            report_mismatch($sformatf("stage %0d max_us %0d, want %0d",
                            x.stage_id, out_item_i.max_us, x.max_us));
          if (out_item_i.event_total != x.event_total)
            report_mismatch($sformatf("stage %0d event_total %0d, want %0d",
                            x.stage_id, out_item_i.event_total, x.event_total));
          if (out_item_i.last_in_report !== x.last_in_report)
            report_mismatch($sformatf("stage %0d last_in_report %0b, want %0b",
                            x.stage_id, out_item_i.last_in_report, x.last_in_report));
        end
      end
      // A transfer at this edge still sees the interval from before the write
      if (in_valid_i && !in_stall_i) apply_transfer(in_item_i);
      if (cfg_we_i) interval_q = cfg_wdata_i;
    end
  end

endmodule

// File: tb/sv/stage_latency_statistics_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_latency_statistics_unit_tb
// Drives directed and random record, report-check and flush transfers with
// random idling and output stalls across several report intervals; a checker
// beside the unit predicts and compares every report entry.
// ----------------------------------------------------------------------------
module stage_latency_statistics_unit_tb;
  import stlat_pkg::*;

  localparam int unsigned NumStages = NumStagesDefault;
  localparam int          CycleLimit = 2_000_000;
  localparam int          DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          stall_random;
  bit          hold_off;
  logic [47:0] clock_ms;

  always #5 clk_i = ~clk_i;

  stage_latency_statistics_unit #(.NumStages(NumStages)) u_top (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),  .in_stall_o (in_stall),  .in_item_i (in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i   (cfg_we),    .cfg_wdata_i(cfg_wdata)
  );

  stage_latency_statistics_unit_checker #(.NumStages(NumStages)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),  .in_stall_i (in_stall),  .in_item_i (in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_we_i   (cfg_we),    .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("stage_latency_statistics_unit regression: fail");
      $finish;
    end
  end

  // Receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(posedge clk_i);
          n++;
        end
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if (stall_random && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input op_e op, input logic [5:0] st, input logic [31:0] amt,
                      input logic [47:0] now, input bit gaps);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid              <= 1'b1;
    in_item.operation     <= op;
    in_item.stage_index   <= st;
    in_item.amount        <= amt;
    in_item.now_ms        <= now;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One random transfer: mostly records in range, some reports and noise
  task automatic random_item(input bit gaps);
    int unsigned r;
    logic [31:0] amt;
    logic [5:0]  st;
    r  = $urandom_range(0, 99);
    st = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                     : 6'($urandom_range(0, NumStages - 1));
    case ($urandom_range(0, 3))
      0: amt = $urandom;
      1: amt = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: amt = $urandom_range(0, 5000);
    endcase
    clock_ms = clock_ms + $urandom_range(0, 400);
    if (r < 55)      send(OP_DURATION, st, amt, 48'($urandom), gaps);
    else if (r < 80) send(OP_EVENTS, st, amt, 48'($urandom), gaps);
    else if (r < 95) send(OP_PERIODIC, 6'($urandom), $urandom,
                          ($urandom_range(0, 15) == 0) ? clock_ms - 48'd500 : clock_ms, gaps);
    else             send(OP_FLUSH, 6'($urandom), $urandom, 48'($urandom) << 16, gaps);
  endtask

  initial begin
    logic [31:0] intervals [4];
    cycle_count  = 0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    stall_random = 1'b0;
    hold_off     = 1'b0;
    clock_ms     = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first periodic notes time, extremes, out of range, wraps
    send(OP_PERIODIC, 6'd63, 32'hFFFF_FFFF, 48'd5000, 1'b0);
    send(OP_FLUSH, 6'd0, 32'd0, 48'd0, 1'b0);
    send(OP_DURATION, 6'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send(OP_DURATION, 6'd0, 32'hFFFF_FFFF, 48'd0, 1'b0);
    send(OP_DURATION, 6'd0, 32'd0, 48'd0, 1'b0);
    send(OP_DURATION, 6'(NumStages - 1), 32'd7, 48'd0, 1'b0);
    send(OP_EVENTS, 6'(NumStages - 1), 32'hFFFF_FFFF, 48'd0, 1'b0);
    send(OP_EVENTS, 6'd3, 32'd12, 48'd0, 1'b0);
    send(OP_DURATION, 6'd63, 32'd99, 48'd0, 1'b0);
    send(OP_EVENTS, 6'(NumStages), 32'd5, 48'd0, 1'b0);
    send(OP_PERIODIC, 6'd0, 32'd0, 48'd5999, 1'b0);
    send(OP_PERIODIC, 6'd0, 32'd0, 48'd4000, 1'b0);
    send(OP_PERIODIC, 6'd0, 32'd0, 48'd6000, 1'b0);
    send(OP_PERIODIC, 6'd0, 32'd0, 48'd9000, 1'b0);
    send(OP_DURATION, 6'd9, 32'd10, 48'd0, 1'b0);
    send(OP_DURATION, 6'd9, 32'd3, 48'd0, 1'b0);
    send(OP_FLUSH, 6'h2A, 32'h5555_AAAA, 48'hAAAA_5555_AAAA, 1'b0);
    go_idle();

    // Extreme intervals, then random phases
    write_interval(32'd0);
    send(OP_EVENTS, 6'd1, 32'd1, 48'd0, 1'b0);
    send(OP_PERIODIC, 6'd0, 32'd0, 48'd9000, 1'b0);
    go_idle();
    write_interval(32'hFFFF_FFFF);
    send(OP_EVENTS, 6'd2, 32'd1, 48'd0, 1'b0);
    send(OP_PERIODIC, 6'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 1'b0);
    send(OP_FLUSH, 6'd0, 32'd0, 48'd0, 1'b0);
    go_idle();

    clock_ms = 48'd9000;
    intervals[0] = 32'd0;
    intervals[1] = 32'd300;
    intervals[2] = IntervalReset;
    intervals[3] = $urandom_range(1, 2000);
    stall_random = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_interval(intervals[ph]);
      for (int k = 0; k < 100; k++) random_item(1'b1);
      go_idle();
    end

    // Long output hold-off while the input keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (20) @(posedge clk_i);
      end
      begin
        for (int k = 0; k < 4; k++) begin
          for (int s = 0; s < 4; s++) send(OP_DURATION, 6'(s), $urandom, 48'd0, 1'b0);
          send(OP_FLUSH, 6'd0, 32'd0, 48'd0, 1'b0);
        end
      end
    join
    hold_off = 1'b0;
    go_idle();

    // Last part with no idling on either side
    stall_random = 1'b0;
    for (int k = 0; k < 60; k++) random_item(1'b0);
    send(OP_FLUSH, 6'd0, 32'd0, 48'd0, 1'b0);
    go_idle();

    if (fail_count == 0) begin
      $display("stage_latency_statistics_unit regression: pass");
    end else begin
      $display("stage_latency_statistics_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/stlat_pkg.sv
hw/rtl/stlat_stat_mem.sv
hw/rtl/stlat_div.sv
hw/rtl/stage_latency_statistics_unit.sv
tb/sv/stage_latency_statistics_unit_checker.sv
tb/sv/stage_latency_statistics_unit_tb.sv
